>>> hw/rtl/i2c_master_byte_controller_unit_defines.svh
// ---------------------------------------------------------------------------
// I2C master byte controller assertion macros
// Concurrent checks on the clock, disabled while reset is held low.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_CONTROLLER_UNIT_DEFINES_SVH
`define I2C_MASTER_BYTE_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define I2CMB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cmb check failed");

// next-cycle implication
`define I2CMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cmb check failed");

`endif

>>> hw/rtl/i2cmb_pkg.sv
// ---------------------------------------------------------------------------
// I2C master byte controller package
// Shared widths, codes, phase encoding and queue slot types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cmb_pkg;

    localparam int UNIT_W     = 14;
    localparam int TIMEOUT_W  = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int KIND_W     = 3;
    localparam int BYTE_W     = 8;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [UNIT_W-1:0]    UNIT_TICKS_RST  = 14'd25;
    localparam logic [TIMEOUT_W-1:0] ACK_TIMEOUT_RST = 16'd250;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TICKS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 1'b1;

    localparam logic [KIND_W-1:0] KIND_START    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STOP     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_WAIT_ACK = 3'd4;
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd5;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_WRITE,
        CMD_WAIT_ACK,
        CMD_READ
    } t_cmd;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_STOP_A,
        PH_STOP_B,
        PH_WR_SET,
        PH_WR_HI,
        PH_WR_LO,
        PH_ACK_REL,
        PH_ACK_HI,
        PH_ACK_POLL,
        PH_RD_LO,
        PH_RD_H1,
        PH_RD_H2,
        PH_AN_LO,
        PH_AN_HI
    } t_phase;

    typedef struct packed {
        t_cmd              cmd;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_level;
    } t_tick;

    typedef struct packed {
        logic  valid;
        t_tick tick;
    } t_slot;

endpackage

>>> hw/rtl/i2cmb_front.sv
// ---------------------------------------------------------------------------
// I2C master byte controller front end
// Accepts input ticks and classifies the command code for the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmb_front (
    input  logic                              i_valid,
    input  logic                              i_full,
    input  logic [i2cmb_pkg::KIND_W-1:0]      i_kind,
    input  logic [i2cmb_pkg::BYTE_W-1:0]      i_tx_byte,
    input  logic                              i_send_ack,
    input  logic                              i_sda_level,
    output i2cmb_pkg::t_slot                  o_push
);

    i2cmb_pkg::t_cmd cmd;

    always_comb begin
        case (i_kind)
            i2cmb_pkg::KIND_START:    cmd = i2cmb_pkg::CMD_START;
            i2cmb_pkg::KIND_STOP:     cmd = i2cmb_pkg::CMD_STOP;
            i2cmb_pkg::KIND_WRITE:    cmd = i2cmb_pkg::CMD_WRITE;
            i2cmb_pkg::KIND_WAIT_ACK: cmd = i2cmb_pkg::CMD_WAIT_ACK;
            i2cmb_pkg::KIND_READ:     cmd = i2cmb_pkg::CMD_READ;
            default:                  cmd = i2cmb_pkg::CMD_NONE;
        endcase
    end

    assign o_push.valid          = i_valid && !i_full;
    assign o_push.tick.cmd       = cmd;
    assign o_push.tick.tx_byte   = i_tx_byte;
    assign o_push.tick.send_ack  = i_send_ack;
    assign o_push.tick.sda_level = i_sda_level;

endmodule

>>> hw/rtl/i2cmb_queue.sv
// ---------------------------------------------------------------------------
// I2C master byte controller tick queue
// Short FIFO between the classifying front end and the line sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmb_queue #(
    parameter int DEPTH = i2cmb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  i2cmb_pkg::t_slot i_push,
    input  logic             i_pop,
    output logic             o_full,
    output i2cmb_pkg::t_slot o_head
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    i2cmb_pkg::t_tick r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count, n_count;
    logic             push, pop;

    assign o_full = (r_count == CNTW'(DEPTH));
    assign push   = i_push.valid;
    assign pop    = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push.tick;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.tick  = r_mem[r_rd_ptr];

endmodule

>>> hw/rtl/i2cmb_seq.sv
// ---------------------------------------------------------------------------
// I2C master byte controller line sequencer
// Steps the bus phase machine once per queued tick and holds the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cmb_seq #(
    parameter int COUNT_WIDTH = i2cmb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  i2cmb_pkg::t_slot                     i_head,
    output logic                                 o_pop,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output logic                                 o_scl_level,
    output logic                                 o_sda_release,
    output logic                                 o_ready_res,
    output logic                                 o_done_res,
    output logic [i2cmb_pkg::BYTE_W-1:0]         o_rx_byte,
    output logic                                 o_ack_failed,
    input  logic                                 i_cfg_we,
    input  logic [i2cmb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [i2cmb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int UW = i2cmb_pkg::UNIT_W;
    localparam int LW = (COUNT_WIDTH > UW + 2) ? COUNT_WIDTH : UW + 2;
    localparam int TW = (COUNT_WIDTH > i2cmb_pkg::TIMEOUT_W) ? COUNT_WIDTH
                                                           : i2cmb_pkg::TIMEOUT_W;
    localparam logic [LW-1:0] LEN_MAX = LW'((64'd1 << COUNT_WIDTH) - 64'd1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    logic [UW-1:0]                       r_unit_ticks;
    logic [i2cmb_pkg::TIMEOUT_W-1:0]     r_ack_timeout;

    i2cmb_pkg::t_phase                   r_phase, n_phase;
    logic [2:0]                          r_bit_idx, n_bit_idx;
    logic [COUNT_WIDTH-1:0]              r_delay, n_delay;
    logic [COUNT_WIDTH-1:0]              r_wait, n_wait;
    logic [i2cmb_pkg::BYTE_W-1:0]        r_shift, n_shift;
    logic                                r_ack_choice, n_ack_choice;
    logic                                r_scl, n_scl;
    logic                                r_sda, n_sda;
    logic [i2cmb_pkg::BYTE_W-1:0]        r_received, n_received;
    logic                                r_fail, n_fail;
    logic                                r_out_valid, n_out_valid;
    logic                                r_ready_res, n_ready_res;
    logic                                r_done_res, n_done_res;

    logic [UW-1:0]          unit_eff;
    logic [LW-1:0]          len_u1, len_u2, len_u4;
    logic [COUNT_WIDTH-1:0] dly1, dly2, dly4;
    logic [COUNT_WIDTH-1:0] dly_dec;
    logic [COUNT_WIDTH-1:0] wait_inc;
    logic                   take, idle, sda_in;
    i2cmb_pkg::t_tick       tick;

    assign tick     = i_head.tick;
    assign sda_in   = tick.sda_level;
    assign take     = i_head.valid && (!r_out_valid || !i_out_stall);
    assign o_pop    = take;
    assign idle     = (r_phase == i2cmb_pkg::PH_IDLE);

    assign unit_eff = (r_unit_ticks == '0) ? UW'(1) : r_unit_ticks;
    assign len_u1   = LW'(unit_eff);
    assign len_u2   = LW'({unit_eff, 1'b0});
    assign len_u4   = LW'({unit_eff, 2'b00});
    assign dly1     = (len_u1 > LEN_MAX) ? COUNT_MAX : COUNT_WIDTH'(len_u1);
    assign dly2     = (len_u2 > LEN_MAX) ? COUNT_MAX : COUNT_WIDTH'(len_u2);
    assign dly4     = (len_u4 > LEN_MAX) ? COUNT_MAX : COUNT_WIDTH'(len_u4);
    assign dly_dec  = (r_delay != '0) ? r_delay - 1'b1 : r_delay;
    assign wait_inc = (r_wait != COUNT_MAX) ? r_wait + 1'b1 : r_wait;

    always_comb begin
        n_phase      = r_phase;
        n_bit_idx    = r_bit_idx;
        n_delay      = r_delay;
        n_wait       = r_wait;
        n_shift      = r_shift;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_received   = r_received;
        n_fail       = r_fail;
        n_out_valid  = r_out_valid && i_out_stall;
        n_ready_res  = r_ready_res;
        n_done_res   = r_done_res;
        if (take) begin
            n_out_valid = 1'b1;
            n_ready_res = idle;
            n_done_res  = 1'b0;
            if (idle) begin
                case (tick.cmd)
                    i2cmb_pkg::CMD_START: begin
                        n_sda   = 1'b1;
                        n_scl   = 1'b1;
                        n_delay = dly4;
                        n_phase = i2cmb_pkg::PH_START_A;
                    end
                    i2cmb_pkg::CMD_STOP: begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_delay = dly4;
                        n_phase = i2cmb_pkg::PH_STOP_A;
                    end
                    i2cmb_pkg::CMD_WRITE: begin
                        n_shift   = tick.tx_byte;
                        n_bit_idx = '0;
                        n_scl     = 1'b0;
                        n_sda     = tick.tx_byte[i2cmb_pkg::BYTE_W-1];
                        n_delay   = dly2;
                        n_phase   = i2cmb_pkg::PH_WR_SET;
                    end
                    i2cmb_pkg::CMD_WAIT_ACK: begin
                        n_sda   = 1'b1;
                        n_delay = dly1;
                        n_phase = i2cmb_pkg::PH_ACK_REL;
                    end
                    i2cmb_pkg::CMD_READ: begin
                        n_shift      = '0;
                        n_bit_idx    = '0;
                        n_ack_choice = tick.send_ack;
                        n_sda        = 1'b1;
                        n_scl        = 1'b0;
                        n_delay      = dly2;
                        n_phase      = i2cmb_pkg::PH_RD_LO;
                    end
                    default: begin
                    end
                endcase
            end else if (r_phase == i2cmb_pkg::PH_ACK_POLL) begin
                if (!sda_in) begin
                    n_scl      = 1'b0;
                    n_fail     = 1'b0;
                    n_phase    = i2cmb_pkg::PH_IDLE;
                    n_done_res = 1'b1;
                end else begin
                    n_wait = wait_inc;
                    if (TW'(wait_inc) > TW'(r_ack_timeout)) begin
                        n_fail  = 1'b1;
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_delay = dly4;
                        n_phase = i2cmb_pkg::PH_STOP_A;
                    end
                end
            end else begin
                n_delay = dly_dec;
                if (dly_dec == '0) begin
                    case (r_phase)
                        i2cmb_pkg::PH_START_A: begin
                            n_sda   = 1'b0;
                            n_delay = dly4;
                            n_phase = i2cmb_pkg::PH_START_B;
                        end
                        i2cmb_pkg::PH_START_B: begin
                            n_scl      = 1'b0;
                            n_phase    = i2cmb_pkg::PH_IDLE;
                            n_done_res = 1'b1;
                        end
                        i2cmb_pkg::PH_STOP_A: begin
                            n_scl   = 1'b1;
                            n_sda   = 1'b1;
                            n_delay = dly4;
                            n_phase = i2cmb_pkg::PH_STOP_B;
                        end
                        i2cmb_pkg::PH_STOP_B: begin
                            n_phase    = i2cmb_pkg::PH_IDLE;
                            n_done_res = 1'b1;
                        end
                        i2cmb_pkg::PH_WR_SET: begin
                            n_scl   = 1'b1;
                            n_delay = dly2;
                            n_phase = i2cmb_pkg::PH_WR_HI;
                        end
                        i2cmb_pkg::PH_WR_HI: begin
                            n_scl   = 1'b0;
                            n_delay = dly2;
                            n_phase = i2cmb_pkg::PH_WR_LO;
                        end
                        i2cmb_pkg::PH_WR_LO: begin
                            if (r_bit_idx == i2cmb_pkg::LAST_BIT) begin
                                n_phase    = i2cmb_pkg::PH_IDLE;
                                n_done_res = 1'b1;
                            end else begin
                                n_bit_idx = r_bit_idx + 1'b1;
                                n_shift   = {r_shift[i2cmb_pkg::BYTE_W-2:0], 1'b0};
                                n_sda     = r_shift[i2cmb_pkg::BYTE_W-2];
                                n_delay   = dly2;
                                n_phase   = i2cmb_pkg::PH_WR_SET;
                            end
                        end
                        i2cmb_pkg::PH_ACK_REL: begin
                            n_scl   = 1'b1;
                            n_delay = dly1;
                            n_phase = i2cmb_pkg::PH_ACK_HI;
                        end
                        i2cmb_pkg::PH_ACK_HI: begin
                            n_wait  = '0;
                            n_phase = i2cmb_pkg::PH_ACK_POLL;
                        end
                        i2cmb_pkg::PH_RD_LO: begin
                            n_scl   = 1'b1;
                            n_delay = dly1;
                            n_phase = i2cmb_pkg::PH_RD_H1;
                        end
                        i2cmb_pkg::PH_RD_H1: begin
                            n_shift = {r_shift[i2cmb_pkg::BYTE_W-2:0], sda_in};
                            n_delay = dly1;
                            n_phase = i2cmb_pkg::PH_RD_H2;
                        end
                        i2cmb_pkg::PH_RD_H2: begin
                            n_scl   = 1'b0;
                            n_delay = dly2;
                            if (r_bit_idx == i2cmb_pkg::LAST_BIT) begin
                                n_sda   = ~r_ack_choice;
                                n_phase = i2cmb_pkg::PH_AN_LO;
                            end else begin
                                n_bit_idx = r_bit_idx + 1'b1;
                                n_phase   = i2cmb_pkg::PH_RD_LO;
                            end
                        end
                        i2cmb_pkg::PH_AN_LO: begin
                            n_scl   = 1'b1;
                            n_delay = dly2;
                            n_phase = i2cmb_pkg::PH_AN_HI;
                        end
                        i2cmb_pkg::PH_AN_HI: begin
                            n_scl      = 1'b0;
                            n_received = r_shift;
                            n_phase    = i2cmb_pkg::PH_IDLE;
                            n_done_res = 1'b1;
                        end
                        default: begin
                            n_phase = i2cmb_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks  <= i2cmb_pkg::UNIT_TICKS_RST;
            r_ack_timeout <= i2cmb_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                i2cmb_pkg::CFG_UNIT_TICKS:  r_unit_ticks  <= i_cfg_data[UW-1:0];
                i2cmb_pkg::CFG_ACK_TIMEOUT: r_ack_timeout <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cmb_pkg::PH_IDLE;
            r_bit_idx    <= '0;
            r_delay      <= '0;
            r_wait       <= '0;
            r_shift      <= '0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_received   <= '0;
            r_fail       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_ready_res  <= 1'b0;
            r_done_res   <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bit_idx    <= n_bit_idx;
            r_delay      <= n_delay;
            r_wait       <= n_wait;
            r_shift      <= n_shift;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_received   <= n_received;
            r_fail       <= n_fail;
            r_out_valid  <= n_out_valid;
            r_ready_res  <= n_ready_res;
            r_done_res   <= n_done_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_scl_level   = r_scl;
    assign o_sda_release = r_sda;
    assign o_ready_res   = r_ready_res;
    assign o_done_res    = r_done_res;
    assign o_rx_byte     = r_received;
    assign o_ack_failed  = r_fail;

endmodule

>>> hw/rtl/i2c_master_byte_controller_unit.sv
// ---------------------------------------------------------------------------
// I2C master byte controller
// Single-master open-drain line sequencer, one result per input tick.
//
//   channel   direction  handshake                 payload
//   in        sink       i_in_valid / o_in_stall   kind, tx_byte, send_ack, sda_level
//   out       source     o_out_valid / i_out_stall scl, sda, ready, done, rx_byte, fail
//   cfg       sink       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One tick is taken per cycle while in stall is low; each tick passes through
// a queue slot, then the sequencer step into the result register.
// The sequencer steps only when the result register is free or being taken.
// The queue holds QUEUE_DEPTH ticks; in stall rises only when it is full.
// Synchronous active-low reset; pins come out of reset released high.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2c_master_byte_controller_unit #(
    parameter int COUNT_WIDTH = i2cmb_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = i2cmb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [i2cmb_pkg::KIND_W-1:0]         i_kind,
    input  logic [i2cmb_pkg::BYTE_W-1:0]         i_tx_byte,
    input  logic                                 i_send_ack,
    input  logic                                 i_sda_level,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_scl_level,
    output logic                                 o_sda_release,
    output logic                                 o_ready_res,
    output logic                                 o_done_res,
    output logic [i2cmb_pkg::BYTE_W-1:0]         o_rx_byte,
    output logic                                 o_ack_failed,
    input  logic                                 i_cfg_we,
    input  logic [i2cmb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [i2cmb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    i2cmb_pkg::t_slot push;
    i2cmb_pkg::t_slot head;
    logic             full;
    logic             pop;

    assign o_in_stall = full;

    i2cmb_front u_front (
        .i_valid     (i_in_valid),
        .i_full      (full),
        .i_kind      (i_kind),
        .i_tx_byte   (i_tx_byte),
        .i_send_ack  (i_send_ack),
        .i_sda_level (i_sda_level),
        .o_push      (push)
    );

    i2cmb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    i2cmb_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_scl_level   (o_scl_level),
        .o_sda_release (o_sda_release),
        .o_ready_res   (o_ready_res),
        .o_done_res    (o_done_res),
        .o_rx_byte     (o_rx_byte),
        .o_ack_failed  (o_ack_failed),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

endmodule

>>> hw/rtl/i2cmb_checker.sv
// ---------------------------------------------------------------------------
// I2C master byte controller port checker
// Watches the result channel of the top level and is bound to it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_byte_controller_unit_defines.svh"

module i2cmb_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic                         o_scl_level,
    input logic                         o_sda_release,
    input logic                         o_ready_res,
    input logic                         o_done_res,
    input logic [i2cmb_pkg::BYTE_W-1:0] o_rx_byte
);

    // hold a stalled result
    `I2CMB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_rx_byte) && $stable(o_done_res) && $stable(o_scl_level))

    // a finishing tick was never an idle tick
    `I2CMB_ASSERT_NOW(a_done_not_ready, i_clk, i_rst_n, o_out_valid && o_done_res, !o_ready_res)

    // only stop ends with SCL released, and then SDA is released too
    `I2CMB_ASSERT_NOW(a_done_scl_high, i_clk, i_rst_n, o_out_valid && o_done_res && o_scl_level, o_sda_release)

endmodule

bind i2c_master_byte_controller_unit i2cmb_checker u_chk (.*);

>>> dv/tb_i2c_master_byte_controller_unit.sv
// ---------------------------------------------------------------------------
// I2C master byte controller testbench
// Feeds line ticks through a queue-fed driver under random bursts and output
// stalls, predicts every result with a cycle model of the sequencer and checks
// each transfer field by field. Covers directed commands, ack timeouts and
// several delay and timeout settings, including zero settings, the widest
// timeout and unit data with its upper bits set.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_i2c_master_byte_controller_unit;

    import i2cmb_pkg::*;

    localparam int CNT_W = COUNT_WIDTH_DEF;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [KIND_W-1:0] KIND_NONE   = CMD_NONE;
    localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd7;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] tx_byte;
        logic              send_ack;
        logic              sda_level;
    } tick_t;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              ready;
        logic              done;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_failed;
    } pins_t;

    typedef struct packed {
        t_phase            phase;
        logic [2:0]        bit_idx;
        logic [CNT_W-1:0]  delay;
        logic [CNT_W-1:0]  polls;
        logic [BYTE_W-1:0] shreg;
        logic              ack_sel;
        logic              scl;
        logic              sda;
        logic [BYTE_W-1:0] rx;
        logic              failed;
        pins_t             res;
    } seq_state_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  o_in_stall;
    tick_t                 drv_tick = '0;
    logic                  o_out_valid;
    logic                  out_stall = 1'b0;
    logic                  o_scl_level;
    logic                  o_sda_release;
    logic                  o_ready_res;
    logic                  o_done_res;
    logic [BYTE_W-1:0]     o_rx_byte;
    logic                  o_ack_failed;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [UNIT_W-1:0]    unit_cfg = UNIT_TICKS_RST;
    logic [TIMEOUT_W-1:0] timeout_cfg = ACK_TIMEOUT_RST;

    tick_t             ticks_to_send[$];
    pins_t             bus_results_due[$];
    logic [KIND_W-1:0] cmd_script[$];
    seq_state_t        gen_st;
    seq_state_t        bus_st;
    int                ack_low_pct = 40;
    int                err_count = 0;
    logic              in_fired = 1'b0;
    int                gap_left = 0;
    int                burst_left = 1;
    int                hold_req = 0;
    int                hold_seen = 0;
    int                hold_cnt = 0;
    int                rx_cnt = 0;
    int                rx_mode = 0;

    i2c_master_byte_controller_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (drv_tick.kind),
        .i_tx_byte     (drv_tick.tx_byte),
        .i_send_ack    (drv_tick.send_ack),
        .i_sda_level   (drv_tick.sda_level),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_scl_level   (o_scl_level),
        .o_sda_release (o_sda_release),
        .o_ready_res   (o_ready_res),
        .o_done_res    (o_done_res),
        .o_rx_byte     (o_rx_byte),
        .o_ack_failed  (o_ack_failed),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic seq_state_t bus_reset_state();
        seq_state_t s;
        s = '0;
        s.phase = PH_IDLE;
        s.scl = 1'b1;
        s.sda = 1'b1;
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] unit_wait(int unsigned units);
        longint unsigned len;
        len = (unit_cfg == 0) ? longint'(units) : longint'(unit_cfg) * units;
        if (len > CNT_MAX) len = CNT_MAX;
        return CNT_W'(len);
    endfunction

    // one line tick of the sequencer: next state plus the pins it shows
    function automatic seq_state_t bus_model_step(seq_state_t s, tick_t t);
        logic rdy;
        logic fin;
        rdy = (s.phase == PH_IDLE);
        fin = 1'b0;
        if (rdy) begin
            case (t.kind)
                KIND_START: begin
                    s.sda = 1'b1;
                    s.scl = 1'b1;
                    s.delay = unit_wait(4);
                    s.phase = PH_START_A;
                end
                KIND_STOP: begin
                    s.scl = 1'b0;
                    s.sda = 1'b0;
                    s.delay = unit_wait(4);
                    s.phase = PH_STOP_A;
                end
                KIND_WRITE: begin
                    s.shreg = t.tx_byte;
                    s.bit_idx = '0;
                    s.scl = 1'b0;
                    s.sda = t.tx_byte[7];
                    s.delay = unit_wait(2);
                    s.phase = PH_WR_SET;
                end
                KIND_WAIT_ACK: begin
                    s.sda = 1'b1;
                    s.delay = unit_wait(1);
                    s.phase = PH_ACK_REL;
                end
                KIND_READ: begin
                    s.shreg = '0;
                    s.bit_idx = '0;
                    s.ack_sel = t.send_ack;
                    s.sda = 1'b1;
                    s.scl = 1'b0;
                    s.delay = unit_wait(2);
                    s.phase = PH_RD_LO;
                end
                default: ;
            endcase
        end else if (s.phase == PH_ACK_POLL) begin
            if (!t.sda_level) begin
                s.scl = 1'b0;
                s.failed = 1'b0;
                s.phase = PH_IDLE;
                fin = 1'b1;
            end else begin
                if (s.polls != CNT_MAX) s.polls = s.polls + 1'b1;
                if (s.polls > timeout_cfg) begin
                    s.failed = 1'b1;
                    s.scl = 1'b0;
                    s.sda = 1'b0;
                    s.delay = unit_wait(4);
                    s.phase = PH_STOP_A;
                end
            end
        end else begin
            if (s.delay != 0) s.delay = s.delay - 1'b1;
            if (s.delay == 0) begin
                case (s.phase)
                    PH_START_A: begin
                        s.sda = 1'b0;
                        s.delay = unit_wait(4);
                        s.phase = PH_START_B;
                    end
                    PH_START_B: begin
                        s.scl = 1'b0;
                        s.phase = PH_IDLE;
                        fin = 1'b1;
                    end
                    PH_STOP_A: begin
                        s.scl = 1'b1;
                        s.sda = 1'b1;
                        s.delay = unit_wait(4);
                        s.phase = PH_STOP_B;
                    end
                    PH_STOP_B: begin
                        s.phase = PH_IDLE;
                        fin = 1'b1;
                    end
                    PH_WR_SET: begin
                        s.scl = 1'b1;
                        s.delay = unit_wait(2);
                        s.phase = PH_WR_HI;
                    end
                    PH_WR_HI: begin
                        s.scl = 1'b0;
                        s.delay = unit_wait(2);
                        s.phase = PH_WR_LO;
                    end
                    PH_WR_LO: begin
                        if (s.bit_idx == LAST_BIT) begin
                            s.phase = PH_IDLE;
                            fin = 1'b1;
                        end else begin
                            s.bit_idx = s.bit_idx + 3'd1;
                            s.shreg = {s.shreg[BYTE_W-2:0], 1'b0};
                            s.sda = s.shreg[BYTE_W-1];
                            s.delay = unit_wait(2);
                            s.phase = PH_WR_SET;
                        end
                    end
                    PH_ACK_REL: begin
                        s.scl = 1'b1;
                        s.delay = unit_wait(1);
                        s.phase = PH_ACK_HI;
                    end
                    PH_ACK_HI: begin
                        s.polls = '0;
                        s.phase = PH_ACK_POLL;
                    end
                    PH_RD_LO: begin
                        s.scl = 1'b1;
                        s.delay = unit_wait(1);
                        s.phase = PH_RD_H1;
                    end
                    PH_RD_H1: begin
                        s.shreg = {s.shreg[BYTE_W-2:0], t.sda_level};
                        s.delay = unit_wait(1);
                        s.phase = PH_RD_H2;
                    end
                    PH_RD_H2: begin
                        s.scl = 1'b0;
                        if (s.bit_idx == LAST_BIT) begin
                            s.sda = !s.ack_sel;
                            s.delay = unit_wait(2);
                            s.phase = PH_AN_LO;
                        end else begin
                            s.bit_idx = s.bit_idx + 3'd1;
                            s.delay = unit_wait(2);
                            s.phase = PH_RD_LO;
                        end
                    end
                    PH_AN_LO: begin
                        s.scl = 1'b1;
                        s.delay = unit_wait(2);
                        s.phase = PH_AN_HI;
                    end
                    PH_AN_HI: begin
                        s.scl = 1'b0;
                        s.rx = s.shreg;
                        s.phase = PH_IDLE;
                        fin = 1'b1;
                    end
                    default: s.phase = PH_IDLE;
                endcase
            end
        end
        s.res.scl = s.scl;
        s.res.sda = s.sda;
        s.res.ready = rdy;
        s.res.done = fin;
        s.res.rx_byte = s.rx;
        s.res.ack_failed = s.failed;
        return s;
    endfunction

    task automatic check_pin(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    // sample transfers, predict on input, compare on output
    always @(posedge i_clk) begin : monitor
        pins_t want;
        if (!i_rst_n) begin
            in_fired <= 1'b0;
            bus_st = bus_reset_state();
        end else begin
            in_fired <= in_valid && !o_in_stall;
            if (in_valid && !o_in_stall) begin
                bus_st = bus_model_step(bus_st, drv_tick);
                bus_results_due.push_back(bus_st.res);
            end
            if (o_out_valid && !out_stall) begin
                if (bus_results_due.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    err_count++;
                end else begin
                    want = bus_results_due.pop_front();
                    check_pin("scl_level", want.scl, o_scl_level);
                    check_pin("sda_release", want.sda, o_sda_release);
                    check_pin("ready_res", want.ready, o_ready_res);
                    check_pin("done_res", want.done, o_done_res);
                    check_pin("rx_byte", want.rx_byte, o_rx_byte);
                    check_pin("ack_failed", want.ack_failed, o_ack_failed);
                end
            end
        end
    end

    // sender: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin : driver
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fired) begin
            if (gap_left != 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (ticks_to_send.size() != 0) begin
                drv_tick <= ticks_to_send.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: one of four stall patterns at a time, long hold-off on request
    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_cnt != 0) begin
            out_stall <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cnt <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            rx_cnt <= rx_cnt + 1;
            if (rx_cnt % 64 == 0) rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= 1'($urandom_range(0, 1));
                2: out_stall <= (rx_cnt % 3 == 0);
                default: out_stall <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic queue_tick(tick_t t);
        gen_st = bus_model_step(gen_st, t);
        ticks_to_send.push_back(t);
    endtask

    // one command on an idle sequencer, then filler ticks until it is idle again
    task automatic queue_cmd(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] tx, logic ack,
                             logic ack_low);
        tick_t t;
        t.kind = kind;
        t.tx_byte = tx;
        t.send_ack = ack;
        t.sda_level = 1'($urandom_range(0, 1));
        queue_tick(t);
        while (gen_st.phase != PH_IDLE) begin
            t.kind = KIND_W'($urandom_range(0, 7));
            t.tx_byte = BYTE_W'($urandom);
            t.send_ack = 1'($urandom_range(0, 1));
            t.sda_level = (gen_st.phase == PH_ACK_POLL) ? !ack_low
                                                        : 1'($urandom_range(0, 1));
            queue_tick(t);
        end
    endtask

    task automatic plan_transfer();
        cmd_script.push_back(KIND_START);
        cmd_script.push_back(KIND_WRITE);
        cmd_script.push_back(KIND_WAIT_ACK);
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 1) == 0) begin
                cmd_script.push_back(KIND_WRITE);
                cmd_script.push_back(KIND_WAIT_ACK);
            end else begin
                cmd_script.push_back(KIND_READ);
            end
        end
        cmd_script.push_back(KIND_STOP);
    endtask

    // mostly well-formed bus transfers, some stray and out-of-order commands
    task automatic queue_random(int n);
        tick_t t;
        for (int i = 0; i < n || gen_st.phase != PH_IDLE; i++) begin
            t.kind = KIND_NONE;
            t.tx_byte = BYTE_W'($urandom);
            t.send_ack = 1'($urandom_range(0, 1));
            t.sda_level = 1'($urandom_range(0, 1));
            if (gen_st.phase == PH_IDLE) begin
                if ($urandom_range(0, 9) == 0) begin
                    t.kind = KIND_W'($urandom_range(0, 7));
                end else begin
                    if (cmd_script.size() == 0) plan_transfer();
                    t.kind = cmd_script.pop_front();
                end
            end else if (gen_st.phase == PH_ACK_POLL) begin
                t.sda_level = ($urandom_range(0, 99) >= ack_low_pct);
            end else if ($urandom_range(0, 7) == 0) begin
                t.kind = KIND_W'($urandom_range(0, 7));
            end
            queue_tick(t);
        end
    endtask

    task automatic drain();
        while (ticks_to_send.size() != 0 || in_valid || bus_results_due.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_UNIT_TICKS) unit_cfg = data[UNIT_W-1:0];
        else timeout_cfg = data[TIMEOUT_W-1:0];
    endtask

    initial begin
        gen_st = bus_reset_state();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings
        queue_random(20);
        drain();

        // directed: zero unit acts as one, zero timeout
        write_reg(CFG_UNIT_TICKS, 16'h0000);
        write_reg(CFG_ACK_TIMEOUT, 16'h0000);
        queue_cmd(KIND_NONE, 8'h00, 1'b0, 1'b1);
        queue_cmd(KIND_RSVD_A, 8'hFF, 1'b1, 1'b1);
        queue_cmd(KIND_RSVD_B, 8'h5A, 1'b0, 1'b1);
        queue_cmd(KIND_START, 8'h00, 1'b0, 1'b1);
        queue_cmd(KIND_WRITE, 8'hFF, 1'b0, 1'b1);
        queue_cmd(KIND_WAIT_ACK, 8'h00, 1'b0, 1'b0);
        queue_cmd(KIND_STOP, 8'h00, 1'b0, 1'b1);
        queue_cmd(KIND_START, 8'h00, 1'b0, 1'b1);
        queue_cmd(KIND_WRITE, 8'h00, 1'b1, 1'b1);
        queue_cmd(KIND_WAIT_ACK, 8'h00, 1'b0, 1'b1);
        queue_cmd(KIND_READ, 8'h00, 1'b1, 1'b1);
        queue_cmd(KIND_READ, 8'hFF, 1'b0, 1'b1);
        queue_cmd(KIND_WRITE, 8'hA5, 1'b0, 1'b1);
        queue_cmd(KIND_WAIT_ACK, 8'h00, 1'b0, 1'b1);
        queue_cmd(KIND_STOP, 8'h00, 1'b0, 1'b1);
        drain();

        // fill the block under a long output hold-off, so that in stall pauses the sender
        write_reg(CFG_UNIT_TICKS, 16'd1);
        write_reg(CFG_ACK_TIMEOUT, 16'd5);
        ack_low_pct = 25;
        queue_random(100);
        hold_req++;
        drain();
        queue_random(100);
        drain();

        write_reg(CFG_UNIT_TICKS, 16'd2);
        write_reg(CFG_ACK_TIMEOUT, 16'hFFFF);
        ack_low_pct = 40;
        queue_random(150);
        drain();

        write_reg(CFG_UNIT_TICKS, 16'd3);
        write_reg(CFG_ACK_TIMEOUT, 16'd1);
        ack_low_pct = 50;
        queue_random(150);
        hold_req++;
        drain();

        // upper unit data bits drop out
        write_reg(CFG_UNIT_TICKS, 16'hC001);
        write_reg(CFG_ACK_TIMEOUT, 16'd2);
        queue_cmd(KIND_WRITE, 8'h3C, 1'b0, 1'b1);
        queue_cmd(KIND_WAIT_ACK, 8'h3C, 1'b1, 1'b1);
        drain();

        repeat (10) @(posedge i_clk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/i2cmb_pkg.sv
hw/rtl/i2cmb_front.sv
hw/rtl/i2cmb_queue.sv
hw/rtl/i2cmb_seq.sv
hw/rtl/i2c_master_byte_controller_unit.sv
hw/rtl/i2cmb_checker.sv
dv/tb_i2c_master_byte_controller_unit.sv
